// ===== sv/ptwa_pkg.sv =====
package ptwa_pkg;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [7:0]  ver;
        logic [31:0] bad_pkt;
        logic [31:0] bad_rte;
        logic [15:0] age;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_RESP
    } state_t;

    localparam logic [2:0] OP_UPDATE  = 3'd0;
    localparam logic [2:0] OP_BAD_RTE = 3'd1;
    localparam logic [2:0] OP_BAD_PKT = 3'd2;
    localparam logic [2:0] OP_LOOKUP  = 3'd3;
    localparam logic [2:0] OP_NEXT    = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd180;

endpackage

// ===== sv/ptwa_cell.sv =====
module ptwa_cell
    import ptwa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  logic   clear,
    input  entry_t d,
    output entry_t q
);

    logic   valid_reg;
    entry_t data_reg;

    // only the valid bit is reset; payload is written on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

// ===== sv/peer_table_with_aging.sv =====
// Peer table: a ring of TABLE_DEPTH entry cells rotating past one head stage.
// Lookup, lookup-next and tick: one ring pass per item.
// Update / bad-route / bad-packet: a search pass, then an apply pass; the apply
// pass is skipped when the table is full. Clear and unused codes: no ring pass.
// One item at a time; done pulses one cycle with the result, no stall possible.
// Async reset empties the table and sets timeout_reg to 180.
module peer_table_with_aging
    import ptwa_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] peer_addr,
    input  logic [7:0]  version,
    input  logic        timeout_we,
    input  logic [15:0] timeout_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] entry_addr,
    output logic [7:0]  entry_version,
    output logic [31:0] bad_packets,
    output logic [31:0] bad_routes,
    output logic [15:0] age
);

    localparam int CW = $clog2(TABLE_DEPTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    op_reg;
    logic [31:0]   key_reg;
    logic [7:0]    ver_reg;
    logic          hit_reg, free_reg, ins_reg, found_reg;
    entry_t        res_reg;
    logic [15:0]   timeout_reg;

    logic   accept, shift, clear_all, last, is_create, match, cap;
    logic   hit_now, free_now;
    entry_t tail, head_out, created, aged;
    entry_t q [TABLE_DEPTH];

    assign accept    = start && !busy;
    assign last      = (cnt_reg == CW'(TABLE_DEPTH - 1));
    assign is_create = (op_reg == OP_UPDATE) || (op_reg == OP_BAD_RTE) ||
                       (op_reg == OP_BAD_PKT);

    // ring of cells; the head stage feeds cell 0 from the last cell
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            ptwa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .clear (clear_all),
                .d     ((g == 0) ? head_out : q[(g == 0) ? 0 : g - 1]),
                .q     (q[g])
            );
        end
    endgenerate

    assign tail     = q[TABLE_DEPTH-1];
    assign match    = tail.valid && (tail.addr == key_reg);
    assign hit_now  = hit_reg || match;
    assign free_now = free_reg || !tail.valid;

    function automatic entry_t apply_op(entry_t e, logic [2:0] op, logic [7:0] v);
        entry_t r;
        r     = e;
        r.age = 16'd0;
        case (op)
            OP_UPDATE:  r.ver = v;
            OP_BAD_RTE: if (e.bad_rte != 32'hFFFF_FFFF) r.bad_rte = e.bad_rte + 32'd1;
            OP_BAD_PKT: if (e.bad_pkt != 32'hFFFF_FFFF) r.bad_pkt = e.bad_pkt + 32'd1;
            default:    r = r;
        endcase
        return r;
    endfunction

    always_comb
    begin
        created         = '0;
        created.valid   = 1'b1;
        created.addr    = key_reg;
        aged            = tail;
        if (tail.age != 16'hFFFF)
        begin
            aged.age = tail.age + 16'd1;
        end
        if (aged.age >= timeout_reg)
        begin
            aged.valid = 1'b0;
        end
    end

    // head stage
    always_comb
    begin
        head_out = tail;
        cap      = 1'b0;
        if (state_reg == ST_SEARCH)
        begin
            case (op_reg)
                OP_LOOKUP: cap = match;
                OP_NEXT:   cap = tail.valid && (tail.addr > key_reg) &&
                                 (!found_reg || (tail.addr < res_reg.addr));
                OP_TICK:   if (tail.valid) head_out = aged;
                default:   cap = 1'b0;
            endcase
        end
        else if (state_reg == ST_APPLY)
        begin
            if (hit_reg && match)
            begin
                head_out = apply_op(tail, op_reg, ver_reg);
                cap      = 1'b1;
            end
            else if (!hit_reg && !ins_reg && !tail.valid)
            begin
                head_out = apply_op(created, op_reg, ver_reg);
                cap      = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode <= OP_TICK)
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_SEARCH:
            begin
                if (last)
                begin
                    if (is_create && (hit_now || free_now))
                        state_next = ST_APPLY;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_APPLY:
            begin
                if (last)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        shift     = (state_reg == ST_SEARCH) || (state_reg == ST_APPLY);
        clear_all = accept && (opcode == OP_CLEAR);
        done      = (state_reg == ST_RESP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            ins_reg     <= 1'b0;
            found_reg   <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (timeout_we)
            begin
                timeout_reg <= timeout_wdata;
            end
            if (accept)
            begin
                cnt_reg   <= '0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                ins_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (shift)
            begin
                cnt_reg <= last ? '0 : cnt_reg + CW'(1);
                if (state_reg == ST_SEARCH)
                begin
                    hit_reg  <= hit_now;
                    free_reg <= free_now;
                end
                if (cap)
                begin
                    found_reg <= 1'b1;
                    ins_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= peer_addr;
            ver_reg <= version;
        end
        if (cap)
        begin
            res_reg <= head_out;
        end
    end

    always_comb
    begin
        found         = found_reg;
        entry_addr    = found_reg ? res_reg.addr    : 32'd0;
        entry_version = found_reg ? res_reg.ver     : 8'd0;
        bad_packets   = found_reg ? res_reg.bad_pkt : 32'd0;
        bad_routes    = found_reg ? res_reg.bad_rte : 32'd0;
        age           = found_reg ? res_reg.age     : 16'd0;
        status        = STS_OK;
        if (!found_reg)
        begin
            if (is_create)
                status = STS_FULL;
            else if ((op_reg == OP_LOOKUP) || (op_reg == OP_NEXT))
                status = STS_NOT_FOUND;
        end
    end

endmodule
